FILE: rtl/rdr_pkg.sv
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared types, constants and the month length table for the calendar
// restore block.
// ----------------------------------------------------------------------------
package rdr_pkg;

	localparam logic [15:0] NO_SAVED_DATE = 16'hFFFF;
	localparam int          DIV_W         = 32;
	localparam int          REM_W         = 17;

	localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;

	// quotient = ((x >> shift) * recip) >> scale, exact over each input range
	localparam logic [25:0] RECIP_DAY  = 26'd50903317;
	localparam logic [13:0] RECIP_HOUR = 14'd9321;
	localparam logic [10:0] RECIP_MIN  = 11'd1093;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [31:0] APB_DATA_ZERO = 32'd0;
	localparam logic        REG_BUILD_YEAR = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_DAY,
		ST_DIV_HOUR,
		ST_DIV_MIN,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_DAY,
		SEL_HOUR,
		SEL_MIN
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		div_sel_t div_sel;
		logic     walk_step;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic div_last;
		logic walk_zero;
	} dp_status_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: rtl/rdr_ctrl.sv
// ----------------------------------------------------------------------------
// rdr_ctrl
// Sequencer: runs the three divisions, then the day-by-day walk, and
// strobes the result; an invalid date goes straight to the result strobe.
// ----------------------------------------------------------------------------
module rdr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output rdr_pkg::dp_cmd_t    cmd,
	input  rdr_pkg::dp_status_t sts
);
	import rdr_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		cmd.load      = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.div_sel   = SEL_DAY;
		cmd.walk_step = 1'b0;
		done          = 1'b0;
		busy          = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DIV_DAY;
				end
			end
			ST_DIV_DAY: begin
				if (sts.bad) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
					cmd.div_sel  = SEL_DAY;
					if (sts.div_last)
						state_nxt = ST_DIV_HOUR;
				end
			end
			ST_DIV_HOUR: begin
				cmd.div_step = 1'b1;
				cmd.div_sel  = SEL_HOUR;
				if (sts.div_last)
					state_nxt = ST_DIV_MIN;
			end
			ST_DIV_MIN: begin
				cmd.div_step = 1'b1;
				cmd.div_sel  = SEL_MIN;
				if (sts.div_last)
					state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (sts.walk_zero)
					state_nxt = ST_DONE;
				else
					cmd.walk_step = 1'b1;
			end
			ST_DONE: begin
				done      = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not followed by idle");
	a_bad_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_DAY && sts.bad) |=> done)
		else $error("invalid date did not finish at once");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy)
		else $error("request loaded while busy");

endmodule

FILE: rtl/rdr_datapath.sv
// ----------------------------------------------------------------------------
// rdr_datapath
// Validity check, reciprocal-multiply splits for days, hours and
// minutes (quotient, then remainder), and the one-day-per-cycle
// calendar stepper.
// ----------------------------------------------------------------------------
module rdr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  rdr_pkg::dp_cmd_t    cmd,
	output rdr_pkg::dp_status_t sts,
	input  logic [6:0]          build_year,
	input  logic [15:0]         saved_date_word,
	input  logic [31:0]         second_count,
	output logic                status,
	output logic [7:0]          year_out,
	output logic [3:0]          month_out,
	output logic [4:0]          day_out,
	output logic [4:0]          hours_out,
	output logic [5:0]          minutes_out,
	output logic [5:0]          seconds_out,
	output logic [15:0]         packed_date_out,
	output logic [15:0]         whole_days
);
	import rdr_pkg::*;

	logic             bad_q;
	logic [7:0]       y_q;
	logic [3:0]       m_q;
	logic [4:0]       d_q;
	logic [DIV_W-1:0] dvd_q;
	logic [15:0]      quo_q;
	logic             phase_q;
	logic [15:0]      days_q;
	logic [15:0]      days_left_q;
	logic [4:0]       hours_q;
	logic [5:0]       minutes_q;
	logic [5:0]       seconds_q;

	logic             bad_in;
	logic [6:0]       y_in;
	logic [3:0]       m_in;
	logic [4:0]       d_in;
	logic [7:0]       y_plus1;

	logic [REM_W-1:0] divisor;
	logic [50:0]      day_prod;
	logic [26:0]      hour_prod;
	logic [20:0]      min_prod;
	logic [15:0]      quo_nxt;
	logic [32:0]      back_prod;
	logic [DIV_W-1:0] rem_nxt;
	logic [4:0]       len;

	// input check
	assign y_in    = saved_date_word[15:9];
	assign m_in    = saved_date_word[8:5];
	assign d_in    = saved_date_word[4:0];
	assign y_plus1 = {1'b0, y_in} + 8'd1;
	assign bad_in  = (saved_date_word == NO_SAVED_DATE)
		|| ((build_year != 7'd0) && (y_plus1 < {1'b0, build_year}))
		|| (m_in < MONTH_JAN) || (m_in > MONTH_DEC) || (d_in == 5'd0);

	// quotient by reciprocal multiply
	assign day_prod  = dvd_q[31:7] * RECIP_DAY;
	assign hour_prod = dvd_q[16:4] * RECIP_HOUR;
	assign min_prod  = dvd_q[11:2] * RECIP_MIN;

	always_comb begin
		case (cmd.div_sel)
			SEL_DAY: begin
				divisor = SECS_PER_DAY;
				quo_nxt = day_prod[50:35];
			end
			SEL_HOUR: begin
				divisor = SECS_PER_HOUR;
				quo_nxt = {10'd0, hour_prod[26:21]};
			end
			SEL_MIN: begin
				divisor = SECS_PER_MIN;
				quo_nxt = {9'd0, min_prod[20:14]};
			end
			default: begin
				divisor = SECS_PER_DAY;
				quo_nxt = day_prod[50:35];
			end
		endcase
	end

	// remainder from the registered quotient
	assign back_prod = quo_q * divisor;
	assign rem_nxt   = dvd_q - back_prod[DIV_W-1:0];

	assign len = month_len(m_q, (y_q[1:0] == 2'b00));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (cmd.load) begin
			phase_q <= 1'b0;
		end else if (cmd.div_step) begin
			phase_q <= !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bad_q <= bad_in;
			y_q   <= {1'b0, y_in};
			m_q   <= m_in;
			d_q   <= d_in;
			dvd_q <= second_count;
		end else if (cmd.div_step) begin
			if (!phase_q) begin
				quo_q <= quo_nxt;
			end else begin
				case (cmd.div_sel)
					SEL_DAY: begin
						days_q      <= quo_q;
						days_left_q <= quo_q;
						dvd_q       <= rem_nxt;
					end
					SEL_HOUR: begin
						hours_q <= quo_q[4:0];
						dvd_q   <= rem_nxt;
					end
					default: begin
						minutes_q <= quo_q[5:0];
						seconds_q <= rem_nxt[5:0];
					end
				endcase
			end
		end else if (cmd.walk_step) begin
			days_left_q <= days_left_q - 16'd1;
			if (d_q < len) begin
				d_q <= d_q + 5'd1;
			end else begin
				d_q <= 5'd1;
				if (m_q < MONTH_DEC) begin
					m_q <= m_q + 4'd1;
				end else begin
					m_q <= MONTH_JAN;
					y_q <= y_q + 8'd1;
				end
			end
		end
	end

	assign sts.bad       = bad_q;
	assign sts.div_last  = phase_q;
	assign sts.walk_zero = (days_left_q == 16'd0);

	assign status          = bad_q;
	assign year_out        = bad_q ? 8'd0 : y_q;
	assign month_out       = bad_q ? 4'd0 : m_q;
	assign day_out         = bad_q ? 5'd0 : d_q;
	assign hours_out       = bad_q ? 5'd0 : hours_q;
	assign minutes_out     = bad_q ? 6'd0 : minutes_q;
	assign seconds_out     = bad_q ? 6'd0 : seconds_q;
	assign packed_date_out = bad_q ? 16'd0 : {y_q[6:0], m_q, d_q};
	assign whole_days      = bad_q ? 16'd0 : days_q;

	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> days_left_q != 16'd0)
		else $error("walk step with no days left");
	a_walk_month: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |=> (m_q >= MONTH_JAN) && (m_q <= MONTH_DEC) && (d_q != 5'd0))
		else $error("walk left the calendar range");
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !phase_q)
		else $error("divider phase not cleared on load");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && phase_q) |-> (rem_nxt < {15'd0, divisor}))
		else $error("remainder not below divisor");

endmodule

FILE: rtl/rtc_date_restore_from_counter.sv
// ----------------------------------------------------------------------------
// rtc_date_restore_from_counter
// Restores a calendar date and time of day from a saved packed date word
// and the raw seconds count of the clock.
//
// Usage:
//   request: drive saved_date_word and second_count with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   result: all result ports are valid for the single cycle in which done
//   is high; the receiver cannot stall, it must take the result then.
//   config: build_year at APB byte address 0, written while idle.
// Sequence:
//   invalid or missing date: straight from the day split state to done.
//   valid date: the day, hour and minute splits (reciprocal multiply,
//   then remainder), then one day per cycle in the calendar stepper,
//   then done. One request at a time; busy stays high until done.
// Reset: arst_n clears the sequencer to idle and build_year to 0.
// ----------------------------------------------------------------------------
module rtc_date_restore_from_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [15:0] saved_date_word,
	input  logic [31:0] second_count,
	output logic        status,
	output logic [7:0]  year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hours_out,
	output logic [5:0]  minutes_out,
	output logic [5:0]  seconds_out,
	output logic [15:0] packed_date_out,
	output logic [15:0] whole_days,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rdr_pkg::*;

	logic [6:0] build_year_q;
	dp_cmd_t    cmd;
	dp_status_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			build_year_q <= 7'd0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUILD_YEAR)) begin
			build_year_q <= pwdata[6:0];
		end
	end

	assign prdata = (paddr[2] == REG_BUILD_YEAR) ? {25'd0, build_year_q} : APB_DATA_ZERO;

	rdr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	rdr_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.build_year      (build_year_q),
		.saved_date_word (saved_date_word),
		.second_count    (second_count),
		.status          (status),
		.year_out        (year_out),
		.month_out       (month_out),
		.day_out         (day_out),
		.hours_out       (hours_out),
		.minutes_out     (minutes_out),
		.seconds_out     (seconds_out),
		.packed_date_out (packed_date_out),
		.whole_days      (whole_days)
	);

endmodule

FILE: verif/tb_rtc_date_restore_from_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtc_date_restore_from_counter
// Self-checking bench for the calendar restore block. Requests go in over
// the start/busy handshake with random gaps. A scoreboard class predicts
// each restored date, time of day and day count from the saved word, the
// seconds count and its own copy of build_year, and checks every done
// strobe in order. build_year is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb_rtc_date_restore_from_counter;
	import rdr_pkg::*;

	localparam int          WATCHDOG_LIMIT = 200000;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          TAIL_CYCLES    = 120;
	localparam int          MAX_REPORTS    = 10;
	localparam int          DAY_SECONDS    = 86400;
	localparam logic [2:0]  ADDR_BUILD_YEAR = {REG_BUILD_YEAR, 2'b00};
	localparam logic [2:0]  ADDR_UNMAPPED   = 3'd4;

	typedef struct packed {
		logic        status;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [15:0] packed_date;
		logic [15:0] days;
	} restored_date_t;

	class restore_scoreboard;
		int unsigned    build_year;
		restored_date_t pending_dates[$];
		int             mismatch_count;
		int unsigned    month_lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		function new();
			build_year = 0;
			mismatch_count = 0;
		endfunction

		function void set_build_year(logic [31:0] value);
			build_year = value[6:0];
		endfunction

		function restored_date_t predict_restore(logic [15:0] word, logic [31:0] count);
			restored_date_t r;
			int unsigned y, m, d, n, len, rem;
			bit bad;
			r = '0;
			y = word[15:9];
			m = word[8:5];
			d = word[4:0];
			bad = (word == NO_SAVED_DATE);
			if (build_year > 0 && y < build_year - 1) bad = 1'b1;
			if (m < 1 || m > 12 || d < 1) bad = 1'b1;
			if (bad) begin
				r.status = 1'b1;
				return r;
			end
			n = count / DAY_SECONDS;
			rem = count % DAY_SECONDS;
			r.days = n[15:0];
			for (int unsigned k = 0; k < n; k++) begin
				len = month_lengths[m - 1];
				if (m == 2 && (y % 4) == 0) len = 29;
				if (d < len) begin
					d++;
				end else begin
					d = 1;
					if (m < 12) begin
						m++;
					end else begin
						m = 1;
						y = (y + 1) % 256;
					end
				end
			end
			r.year = y[7:0];
			r.month = m[3:0];
			r.day = d[4:0];
			r.hours = 5'(rem / 3600);
			r.minutes = 6'((rem % 3600) / 60);
			r.seconds = 6'(rem % 60);
			r.packed_date = 16'((y << 9) | (m << 5) | d);
			return r;
		endfunction

		function void note_request(logic [15:0] word, logic [31:0] count);
			pending_dates.push_back(predict_restore(word, count));
		endfunction

		function void check_result(restored_date_t got);
			restored_date_t want;
			if (pending_dates.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result %p", got);
				return;
			end
			want = pending_dates.pop_front();
			if (got.status !== want.status || got.year !== want.year ||
			    got.month !== want.month || got.day !== want.day ||
			    got.hours !== want.hours || got.minutes !== want.minutes ||
			    got.seconds !== want.seconds || got.packed_date !== want.packed_date ||
			    got.days !== want.days) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("mismatch: expected %p actual %p", want, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	logic [15:0] saved_date_word = '0;
	logic [31:0] second_count = '0;
	logic        status;
	logic [7:0]  year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hours_out;
	logic [5:0]  minutes_out;
	logic [5:0]  seconds_out;
	logic [15:0] packed_date_out;
	logic [15:0] whole_days;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	restore_scoreboard sb = new();
	int idle_cycles = 0;

	rtc_date_restore_from_counter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.saved_date_word(saved_date_word), .second_count(second_count),
		.status(status), .year_out(year_out), .month_out(month_out), .day_out(day_out),
		.hours_out(hours_out), .minutes_out(minutes_out), .seconds_out(seconds_out),
		.packed_date_out(packed_date_out), .whole_days(whole_days),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({status, year_out, month_out, day_out, hours_out,
				minutes_out, seconds_out, packed_date_out, whole_days});
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_rtc_date_restore_from_counter NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int unsigned random_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] make_date(int unsigned y, int unsigned m, int unsigned d);
		return 16'((y << 9) | (m << 5) | d);
	endfunction

	function automatic logic [15:0] random_date_word();
		int unsigned pick, floor_year;
		pick = $urandom_range(0, 99);
		floor_year = (sb.build_year > 0) ? sb.build_year - 1 : 0;
		if (pick < 8) return 16'($urandom_range(0, 16'hFFFF));
		if (pick < 11) return NO_SAVED_DATE;
		if (pick < 20)
			return make_date($urandom_range(floor_year, 127), $urandom_range(0, 15),
				$urandom_range(0, 31));
		return make_date($urandom_range(floor_year, 127), $urandom_range(1, 12),
			$urandom_range(1, 31));
	endfunction

	function automatic logic [31:0] random_count();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) return $urandom();
		if (pick < 20) return $urandom_range(0, DAY_SECONDS - 1);
		return $urandom_range(0, 400 * DAY_SECONDS);
	endfunction

	task automatic issue_restore(logic [15:0] word, logic [31:0] count);
		int unsigned gap;
		gap = random_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		saved_date_word <= word;
		second_count <= count;
		do @(posedge clk); while (busy);
		sb.note_request(word, count);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_dates.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_BUILD_YEAR) sb.set_build_year(data);
	endtask

	task automatic run_random(int n, bit with_pause);
		for (int i = 0; i < n; i++) begin
			if (with_pause && i == n / 2) quiesce();
			issue_restore(random_date_word(), random_count());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// build_year still at its reset value of zero
		issue_restore(NO_SAVED_DATE, 32'h1234_5678);
		issue_restore(make_date(20, 0, 5), 32'd100);
		issue_restore(make_date(20, 13, 5), 32'd100);
		issue_restore(make_date(20, 15, 31), 32'd100);
		issue_restore(make_date(20, 6, 0), 32'd100);
		issue_restore(16'h0000, 32'd0);
		issue_restore(make_date(0, 1, 1), 32'd0);
		issue_restore(make_date(25, 7, 14), DAY_SECONDS - 1);
		issue_restore(make_date(24, 2, 30), DAY_SECONDS);
		issue_restore(make_date(23, 2, 29), DAY_SECONDS);
		issue_restore(make_date(24, 2, 28), DAY_SECONDS + 3661);
		issue_restore(make_date(23, 2, 28), DAY_SECONDS);
		issue_restore(make_date(30, 4, 31), 2 * DAY_SECONDS);
		issue_restore(make_date(127, 12, 31), DAY_SECONDS);
		issue_restore(make_date(127, 12, 31), 32'hFFFF_FFFF);
		issue_restore(make_date(99, 12, 31), 400 * DAY_SECONDS + 59);

		quiesce();
		apb_write(ADDR_BUILD_YEAR, 32'd99);
		issue_restore(make_date(97, 5, 5), 32'd500);
		issue_restore(make_date(98, 5, 5), 32'd500);
		issue_restore(make_date(127, 1, 31), 40 * DAY_SECONDS);
		issue_restore(make_date(0, 3, 3), 32'd0);
		run_random(25, 1'b0);

		quiesce();
		apb_write(ADDR_BUILD_YEAR, 32'd1);
		issue_restore(make_date(0, 1, 1), 366 * DAY_SECONDS);
		run_random(25, 1'b1);

		quiesce();
		apb_write(ADDR_BUILD_YEAR, $urandom_range(2, 98));
		apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
		issue_restore(make_date(0, 1, 1), 32'd10);
		run_random(25, 1'b0);

		quiesce();
		apb_write(ADDR_BUILD_YEAR, 32'd0);
		run_random(25, 1'b0);

		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_dates.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending_dates.size() == 0)
			$display("tb_rtc_date_restore_from_counter OK");
		else
			$display("tb_rtc_date_restore_from_counter NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/rdr_pkg.sv
rtl/rdr_ctrl.sv
rtl/rdr_datapath.sv
rtl/rtc_date_restore_from_counter.sv
verif/tb_rtc_date_restore_from_counter.sv
